>>> rtl/core/ptwe_pkg.sv
// Shared types and constants of the page table walk engine.
`default_nettype none

package ptwe_pkg;

    localparam int NUM_TABLES_DEF = 64;
    localparam int TBL_ENTRIES    = 512;
    localparam int SLOT_W         = 9;
    localparam int VA_W           = 48;
    localparam int PA_W           = 48;
    localparam int PAGE_W         = 36;
    localparam int DESC_W         = 64;
    localparam int ROOT_W         = 6;
    localparam int LIMIT_W        = 49;
    localparam int STATUS_W       = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 49;

    // Command codes
    typedef logic [1:0] action_t;
    localparam action_t ACT_CREATE    = 2'd0;
    localparam action_t ACT_MAP       = 2'd1;
    localparam action_t ACT_UNMAP     = 2'd2;
    localparam action_t ACT_TRANSLATE = 2'd3;

    // Result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_NO_TABLES  = 3'd1;
    localparam status_t ST_NOT_USER   = 3'd2;
    localparam status_t ST_NOT_MAPPED = 3'd3;
    localparam status_t ST_NO_ROOT    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] USER_LIMIT_RST = 49'h0_0080_0000_0000;

    // Descriptor bits
    localparam logic [DESC_W-1:0] DESC_VALID = 64'h1;
    localparam logic [DESC_W-1:0] DESC_TABLE = 64'h2;
    localparam logic [DESC_W-1:0] DESC_PAGE  = 64'h2;

    typedef struct packed {
        action_t           action;
        logic [ROOT_W-1:0] root_index;
        logic [VA_W-1:0]   vaddr;
        logic [PA_W-1:0]   paddr;
        logic [DESC_W-1:0] attr_flags;
        logic              user_check;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [DESC_W-1:0] result_addr;
        logic [ROOT_W-1:0] new_root_index;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/ptwe_cmd_if.sv
// Command channel of the page table walk engine.
`default_nettype none

interface ptwe_cmd_if;
    import ptwe_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ptwe_rsp_if.sv
// Response channel of the page table walk engine.
`default_nettype none

interface ptwe_rsp_if;
    import ptwe_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ptwe_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module ptwe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/page_table_map_walk_engine.sv
// Page table walk engine top level: command sequencer around the table memory.
//
//   channel  dir  handshake       payload
//   cmd      in   valid/ready     action, root_index, vaddr, paddr,
//                                 attr_flags, user_check
//   rsp      out  valid/ready     status, result_addr, new_root_index
//   cfg      in   cfg_we          cfg_index, cfg_data (write only)
//
// One command at a time; each walk level takes a read and an evaluate state on
// the single-port table memory. Create-root and early rejects go straight to
// S_RESP; map and unmap walk three levels and write or clear the leaf in S_LEAF,
// while a translate walk reads all four; a walk may stop early. After reset the
// memory is cleared one entry a cycle over all NUM_TABLES*512 entries (32768 by
// default), cmd.ready low; a result blocked on rsp.ready holds S_RESP.
`default_nettype none

module page_table_map_walk_engine #(
    parameter int NUM_TABLES = ptwe_pkg::NUM_TABLES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    ptwe_cmd_if.sink                             cmd,
    ptwe_rsp_if.source                           rsp,
    input  wire logic                            cfg_we,
    input  wire logic [ptwe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptwe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ptwe_pkg::*;

    localparam int DEPTH = NUM_TABLES * TBL_ENTRIES;
    localparam int TW    = $clog2(NUM_TABLES);
    localparam int AW    = TW + SLOT_W;
    localparam int NFW   = $clog2(NUM_TABLES + 1);
    localparam int CW    = (NFW > ROOT_W) ? NFW : ROOT_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    typedef logic [1:0] level_t;
    localparam level_t LVL_LAST_TABLE = 2'd2;
    localparam level_t LVL_LEAF       = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_LEAF,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    level_t            level_reg, level_next;
    logic [TW-1:0]     t_reg, t_next;
    logic [NFW-1:0]    nf_reg, nf_next;
    logic [AW-1:0]     clr_reg, clr_next;
    cmd_t              cmd_reg, cmd_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [PA_W-1:0]    pool_base_reg;
    logic [LIMIT_W-1:0] user_va_limit_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [DESC_W-1:0] ram_wdata;
    logic [DESC_W-1:0] desc;

    logic [PAGE_W-1:0] base_page;
    logic [PAGE_W-1:0] dec_off;
    logic              dec_ok;
    logic              can_alloc;
    logic [PA_W-1:0]   alloc_addr;
    logic [SLOT_W-1:0] cur_slot;

    // Table index of the current level
    function automatic logic [SLOT_W-1:0] va_slot(input logic [VA_W-1:0] va,
                                                  input level_t lvl);
        logic [SLOT_W-1:0] s;
        unique case (lvl)
            2'd0:    s = va[47:39];
            2'd1:    s = va[38:30];
            2'd2:    s = va[29:21];
            default: s = va[20:12];
        endcase
        return s;
    endfunction

    ptwe_ram #(
        .WIDTH (DESC_W),
        .DEPTH (DEPTH)
    ) u_tables (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (desc)
    );

    // Decode a table descriptor against the pool; address the next free table
    assign base_page  = pool_base_reg[PA_W-1:12];
    assign dec_off    = desc[PA_W-1:12] - base_page;
    assign dec_ok     = dec_off < PAGE_W'(nf_reg);
    assign can_alloc  = nf_reg != NFW'(NUM_TABLES);
    assign alloc_addr = {base_page + PAGE_W'(nf_reg), 12'h000};
    assign cur_slot   = va_slot(cmd_reg.vaddr, level_reg);

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // Sequence commands through the table memory
    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        t_next         = t_reg;
        nf_next        = nf_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_addr       = {t_reg, cur_slot};
        ram_wdata      = '0;

        // Drop the result once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd.data;
                    t_next     = TW'(cmd.data.root_index);
                    level_next = '0;
                    res_next   = '0;
                    state_next = S_RESP;
                    priority if (cmd.data.action == ACT_CREATE)
                    begin
                        if (can_alloc)
                        begin
                            res_next.result_addr    = DESC_W'(alloc_addr);
                            res_next.new_root_index = ROOT_W'(nf_reg);
                            nf_next                 = nf_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_NO_TABLES;
                        end
                    end
                    else if (CW'(cmd.data.root_index) >= CW'(nf_reg))
                    begin
                        res_next.status = ST_NO_ROOT;
                    end
                    else if (cmd.data.action == ACT_MAP && cmd.data.user_check &&
                             {1'b0, cmd.data.vaddr} >= user_va_limit_reg)
                    begin
                        res_next.status = ST_NOT_USER;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (level_reg == LVL_LEAF)
                begin
                    // Only translate reads the leaf
                    state_next = S_RESP;
                    if (desc[0])
                    begin
                        res_next.result_addr = {desc[DESC_W-1:12],
                                                cmd_reg.vaddr[11:0]};
                    end
                    else
                    begin
                        res_next.status = ST_NOT_MAPPED;
                    end
                end
                else
                begin
                    level_next = level_reg + 1'b1;
                    if (level_reg == LVL_LAST_TABLE)
                    begin
                        state_next = (cmd_reg.action == ACT_TRANSLATE) ? S_READ : S_LEAF;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end

                    if (cmd_reg.action == ACT_MAP)
                    begin
                        if (desc[0] && desc[1] && dec_ok)
                        begin
                            t_next = dec_off[TW-1:0];
                        end
                        else if (can_alloc)
                        begin
                            // Link a fresh table into the parent entry
                            ram_we    = 1'b1;
                            ram_wdata = DESC_W'(alloc_addr) | DESC_TABLE | DESC_VALID;
                            t_next    = nf_reg[TW-1:0];
                            nf_next   = nf_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_NO_TABLES;
                            state_next      = S_RESP;
                        end
                    end
                    else if (desc[0] && dec_ok)
                    begin
                        t_next = dec_off[TW-1:0];
                    end
                    else
                    begin
                        res_next.status = ST_NOT_MAPPED;
                        state_next      = S_RESP;
                    end
                end
            end

            S_LEAF:
            begin
                // Write the leaf, or clear it on unmap
                ram_we = 1'b1;
                if (cmd_reg.action == ACT_MAP)
                begin
                    ram_wdata = DESC_W'({cmd_reg.paddr[PA_W-1:12], 12'h000}) |
                                cmd_reg.attr_flags | DESC_PAGE;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            nf_reg        <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            level_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nf_reg        <= nf_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            level_reg     <= level_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg     <= '0;
            user_va_limit_reg <= USER_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE:  pool_base_reg     <= cfg_data[PA_W-1:0];
                CFG_USER_LIMIT: user_va_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:        pool_base_reg     <= pool_base_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= NFW'(NUM_TABLES))
        else $error("table count beyond pool size");

    a_nf_step: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg == $past(nf_reg)) || (nf_reg == $past(nf_reg) + 1'b1))
        else $error("table count moved by more than one");

    a_write_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != S_CLEAR) |-> (NFW'(ram_addr[AW-1:SLOT_W]) < nf_reg))
        else $error("descriptor write into an unallocated table");

    a_leaf_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEAF) |-> (level_reg == LVL_LEAF))
        else $error("leaf write before the last level");
`endif

endmodule

`default_nettype wire

>>> tb/page_table_map_walk_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the page table walk engine: directed and random commands.
module page_table_map_walk_engine_tb;
    import ptwe_pkg::*;

    localparam int POOL_TABLES = NUM_TABLES_DEF;
    localparam int STORE_DEPTH = POOL_TABLES * TBL_ENTRIES;
    localparam int QUIET_LIMIT = 100000;
    localparam int GAP_PCT     = 24;
    localparam int PRINT_CAP   = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptwe_cmd_if cmd_ch ();
    ptwe_rsp_if rsp_ch ();

    page_table_map_walk_engine #(
        .NUM_TABLES (POOL_TABLES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the table pool and the registers
    logic [DESC_W-1:0]  desc_mem [STORE_DEPTH] = '{default: '0};
    int unsigned        tables_used = 0;
    logic [PA_W-1:0]    pool_base_q;
    logic [LIMIT_W-1:0] user_limit_q;

    cmd_t        cmd_backlog [$];
    rsp_t        want_rsp_q [$];
    logic [26:0] region_tag [3];
    bit          gaps_on;
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned quiet_cycles = 0;
    int unsigned cmd_seen [4] = '{default: 0};
    int unsigned status_seen [8] = '{default: 0};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Address of pool table idx, wrapping at 48 bits
    function automatic logic [PA_W-1:0] table_base(input int unsigned idx);
        logic [PAGE_W-1:0] pg;
        pg = pool_base_q[PA_W-1:12] + PAGE_W'(idx);
        return {pg, 12'h000};
    endfunction

    // Map a descriptor address back to an allocated pool index
    function automatic bit locate_table(input logic [DESC_W-1:0] desc,
                                        output int unsigned idx);
        logic [PAGE_W-1:0] off;
        off = desc[PA_W-1:12] - pool_base_q[PA_W-1:12];
        idx = 0;
        if (off >= PAGE_W'(tables_used))
            return 1'b0;
        idx = off[31:0];
        return 1'b1;
    endfunction

    // Hand out the next table, cleared
    function automatic bit take_table(output int unsigned idx);
        idx = tables_used;
        if (tables_used >= POOL_TABLES)
            return 1'b0;
        for (int k = 0; k < TBL_ENTRIES; k++)
            desc_mem[idx * TBL_ENTRIES + k] = '0;
        tables_used++;
        return 1'b1;
    endfunction

    function automatic int unsigned va_slot(input logic [VA_W-1:0] va, input int unsigned lvl);
        return 32'((va >> (39 - 9 * lvl)) & 48'h1FF);
    endfunction

    // Apply one command to the shadow pool and return the reply it must give
    function automatic rsp_t apply_cmd(input cmd_t c);
        rsp_t              r;
        int unsigned       t;
        int unsigned       nxt;
        int unsigned       pos;
        logic [DESC_W-1:0] d;
        r = '0;
        r.status = ST_OK;
        t = 32'(c.root_index);
        if (c.action == ACT_CREATE)
        begin
            if (take_table(nxt))
            begin
                r.result_addr    = {16'h0, table_base(nxt)};
                r.new_root_index = nxt[ROOT_W-1:0];
            end
            else
                r.status = ST_NO_TABLES;
        end
        else if (c.root_index >= tables_used)
            r.status = ST_NO_ROOT;
        else if (c.action == ACT_MAP)
        begin
            if (c.user_check && {1'b0, c.vaddr} >= user_limit_q)
                r.status = ST_NOT_USER;
            else
            begin
                // Follow valid table descriptors, allocate over missing or stale ones
                for (int lvl = 0; lvl < 3 && r.status == ST_OK; lvl++)
                begin
                    pos = t * TBL_ENTRIES + va_slot(c.vaddr, lvl);
                    d = desc_mem[pos];
                    if (d[0] && d[1] && locate_table(d, nxt))
                        t = nxt;
                    else if (take_table(nxt))
                    begin
                        desc_mem[pos] = {16'h0, table_base(nxt)} | DESC_TABLE | DESC_VALID;
                        t = nxt;
                    end
                    else
                        r.status = ST_NO_TABLES;
                end
                if (r.status == ST_OK)
                    desc_mem[t * TBL_ENTRIES + va_slot(c.vaddr, 3)] =
                        ({16'h0, c.paddr} & ~64'hFFF) | c.attr_flags | DESC_PAGE;
            end
        end
        else
        begin
            // Walk existing tables only
            for (int lvl = 0; lvl < 3 && r.status == ST_OK; lvl++)
            begin
                d = desc_mem[t * TBL_ENTRIES + va_slot(c.vaddr, lvl)];
                if (d[0] && locate_table(d, nxt))
                    t = nxt;
                else
                    r.status = ST_NOT_MAPPED;
            end
            if (r.status == ST_OK)
            begin
                pos = t * TBL_ENTRIES + va_slot(c.vaddr, 3);
                if (c.action == ACT_UNMAP)
                    desc_mem[pos] = '0;
                else if (desc_mem[pos][0])
                    r.result_addr = (desc_mem[pos] & ~64'hFFF) | {52'h0, c.vaddr[11:0]};
                else
                    r.status = ST_NOT_MAPPED;
            end
        end
        return r;
    endfunction

    function automatic void push_cmd(input action_t act, input int unsigned root,
                                     input logic [63:0] va, input logic [63:0] pa,
                                     input logic [63:0] attr, input bit uc);
        cmd_t c;
        c.action     = act;
        c.root_index = root[ROOT_W-1:0];
        c.vaddr      = va[VA_W-1:0];
        c.paddr      = pa[PA_W-1:0];
        c.attr_flags = attr;
        c.user_check = uc;
        cmd_backlog.push_back(c);
    endfunction

    // Pick three address regions that share upper-level tables
    function automatic void pick_regions();
        logic [8:0] l0;
        logic [8:0] l1a;
        logic [8:0] l1b;
        l0  = ($urandom_range(0, 1) == 0) ? 9'd0 : 9'($urandom());
        l1a = 9'($urandom());
        l1b = 9'($urandom());
        region_tag[0] = {l0, l1a, 9'($urandom())};
        region_tag[1] = {l0, l1a, 9'($urandom())};
        region_tag[2] = {l0, l1b, 9'($urandom())};
    endfunction

    // Queue a create-root; return its index, or 0 if the pool is full (only called while idle)
    function automatic int unsigned fresh_root();
        push_cmd(ACT_CREATE, 0, rand64(), rand64(), rand64(), 1'b0);
        return (tables_used < POOL_TABLES) ? tables_used : 0;
    endfunction

    // Mostly walks inside the current regions, with some stray roots and noise
    function automatic void queue_walks(input int unsigned n, input int unsigned home);
        int unsigned       roll;
        int unsigned       root;
        logic [8:0]        leaf_slot;
        logic [63:0]       va;
        logic [63:0]       attr;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            leaf_slot = ($urandom_range(0, 3) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 7));
            va = {16'h0, region_tag[$urandom_range(0, 2)], leaf_slot, 12'($urandom())};
            root = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 63) : home;
            attr = rand64();
            if ($urandom_range(0, 99) < 85)
                attr[0] = 1'b1;
            if (roll < 5)
                push_cmd(action_t'($urandom_range(1, 3)), $urandom_range(0, 63),
                         rand64(), rand64(), rand64(), 1'($urandom()));
            else if (roll < 6)
                push_cmd(ACT_CREATE, $urandom_range(0, 63), rand64(), rand64(), rand64(),
                         1'($urandom()));
            else if (roll < 42)
                push_cmd(ACT_MAP, root, va, rand64(), attr, $urandom_range(0, 99) < 30);
            else if (roll < 57)
                push_cmd(ACT_UNMAP, root, va, rand64(), rand64(), 1'($urandom()));
            else
                push_cmd(ACT_TRANSLATE, root, va, rand64(), rand64(), 1'($urandom()));
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POOL_BASE)
            pool_base_q = value[PA_W-1:0];
        else
            user_limit_q = value[LIMIT_W-1:0];
    endtask

    // Wait for every queued item to finish, sampled between edges, then let the engine settle
    task automatic settle();
        while (cmd_backlog.size() != 0 || cmd_ch.valid || want_rsp_q.size() != 0)
            @(negedge clk);
        repeat (24) @(posedge clk);
    endtask

    // Command driver: present the next item, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin : cmd_drive
        rsp_t want;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                want = apply_cmd(cmd_ch.data);
                want_rsp_q.push_back(want);
                cmd_seen[cmd_ch.data.action]++;
                status_seen[want.status]++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() != 0 && !(gaps_on && $urandom_range(0, 99) < GAP_PCT))
                begin
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.data  <= cmd_backlog.pop_front();
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Reply monitor: compare each accepted item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : rsp_check
        rsp_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                checked++;
                if (want_rsp_q.size() == 0)
                    report_mismatch($sformatf("unexpected reply, status %0d addr %h",
                                              rsp_ch.data.status, rsp_ch.data.result_addr));
                else
                begin
                    want = want_rsp_q.pop_front();
                    if (rsp_ch.data.status !== want.status)
                        report_mismatch($sformatf("reply %0d status %0d, want %0d", checked,
                                                  rsp_ch.data.status, want.status));
                    if (rsp_ch.data.result_addr !== want.result_addr)
                        report_mismatch($sformatf("reply %0d result_addr %h, want %h", checked,
                                                  rsp_ch.data.result_addr, want.result_addr));
                    if (rsp_ch.data.new_root_index !== want.new_root_index)
                        report_mismatch($sformatf("reply %0d new_root_index %0d, want %0d",
                                                  checked, rsp_ch.data.new_root_index,
                                                  want.new_root_index));
                end
            end
            rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PCT);
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : main_seq
        int unsigned home;
        int unsigned spare;
        logic [63:0] tmp;
        logic [63:0] probe_va;

        // Hold every input at a known value through reset
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        gaps_on      = 1'b1;
        pool_base_q  = '0;
        user_limit_q = USER_LIMIT_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Phase 1: random unaligned pool base, default user limit
        tmp = rand64();
        write_reg(CFG_POOL_BASE, tmp[CFG_DATA_W-1:0]);
        write_reg(CFG_USER_LIMIT, USER_LIMIT_RST);

        // Commands against roots that do not exist yet
        push_cmd(ACT_TRANSLATE, 0, 64'h7F_FFFF_FFFF, 0, 0, 1'b0);
        push_cmd(ACT_MAP, 63, '1, '1, '1, 1'b1);
        push_cmd(ACT_UNMAP, 0, 64'h7F_FFFF_FFFF, 0, 0, 1'b0);
        // Two roots, then walks over empty tables
        push_cmd(ACT_CREATE, 0, 0, 0, 0, 1'b0);
        push_cmd(ACT_CREATE, 63, '1, '1, '1, 1'b1);
        push_cmd(ACT_TRANSLATE, 0, 64'h7F_FFFF_FFFF, 0, 0, 1'b0);
        push_cmd(ACT_UNMAP, 0, 64'h7F_FFFF_FFFF, 0, 0, 1'b0);
        // User limit: rejected at the limit, accepted just below it
        push_cmd(ACT_MAP, 0, 64'h80_0000_0000, rand64(), rand64(), 1'b1);
        push_cmd(ACT_MAP, 0, 64'h7F_FFFF_FFFF, '1, 64'h1, 1'b1);
        push_cmd(ACT_TRANSLATE, 0, 64'h7F_FFFF_FFFF, 0, 0, 1'b0);
        // Unmap of a leaf that was never written
        push_cmd(ACT_UNMAP, 0, 64'h7F_FFFF_E123, 0, 0, 1'b0);
        // Top of the address space, then a remap of the same page
        push_cmd(ACT_MAP, 0, 64'hFFFF_FFFF_FFFF, 0, '1, 1'b0);
        push_cmd(ACT_TRANSLATE, 0, 64'hFFFF_FFFF_FFFF, 0, 0, 1'b0);
        push_cmd(ACT_MAP, 0, 64'hFFFF_FFFF_FFFF, rand64(), 64'h1, 1'b0);
        push_cmd(ACT_TRANSLATE, 0, 64'hFFFF_FFFF_F000, 0, 0, 1'b1);
        // Leaf without its valid bit
        push_cmd(ACT_MAP, 0, 0, rand64(), 0, 1'b1);
        push_cmd(ACT_TRANSLATE, 0, 0, 0, 0, 1'b0);
        push_cmd(ACT_UNMAP, 0, 0, 0, 0, 1'b0);
        push_cmd(ACT_UNMAP, 0, 64'h7F_FFFF_FFFF, 0, 0, 1'b0);
        push_cmd(ACT_TRANSLATE, 0, 64'h7F_FFFF_FFFF, 0, 0, 1'b0);
        // Second root
        probe_va = rand64();
        push_cmd(ACT_MAP, 1, probe_va, rand64(), rand64() | 64'h1, 1'b0);
        push_cmd(ACT_TRANSLATE, 1, probe_va, 0, 0, 1'b0);
        settle();
        pick_regions();
        queue_walks(300, 0);
        settle();

        // Phase 2: top pool base, user limit zero; old descriptors go stale
        tmp = rand64();
        write_reg(CFG_POOL_BASE, {1'b1, 36'hF_FFFF_FFFF, tmp[11:0]});
        write_reg(CFG_USER_LIMIT, '0);
        push_cmd(ACT_TRANSLATE, 0, 64'hFFFF_FFFF_FFFF, 0, 0, 1'b0);
        push_cmd(ACT_MAP, 0, 64'hFFFF_FFFF_FFFF, rand64(), 64'h1, 1'b0);
        push_cmd(ACT_TRANSLATE, 0, 64'hFFFF_FFFF_FFFF, 0, 0, 1'b0);
        home = fresh_root();
        pick_regions();
        queue_walks(300, home);
        settle();

        // Phase 3: zero pool base, no user limit, no gaps on either side
        write_reg(CFG_POOL_BASE, '0);
        write_reg(CFG_USER_LIMIT, 49'h1_0000_0000_0000);
        gaps_on = 1'b0;
        home = fresh_root();
        pick_regions();
        queue_walks(400, home);
        settle();
        gaps_on = 1'b1;

        // Phase 4: random user limit, same regions kept
        tmp = rand64();
        write_reg(CFG_USER_LIMIT, {1'b0, tmp[47:0]});
        home = fresh_root();
        queue_walks(400, home);
        settle();

        // Drain the pool so a map runs out halfway down its walk
        spare = (tables_used + 2 < POOL_TABLES) ? POOL_TABLES - tables_used - 2 : 0;
        home = (spare > 0) ? tables_used + spare - 1 : 0;
        repeat (spare)
            push_cmd(ACT_CREATE, 0, rand64(), rand64(), rand64(), 1'b0);
        probe_va = rand64();
        push_cmd(ACT_MAP, home, probe_va, rand64(), 64'h1, 1'b0);
        push_cmd(ACT_TRANSLATE, home, probe_va, 0, 0, 1'b0);
        push_cmd(ACT_MAP, home, probe_va, rand64(), 64'h1, 1'b0);
        push_cmd(ACT_CREATE, 0, 0, 0, 0, 1'b0);
        push_cmd(ACT_CREATE, 0, '1, '1, '1, 1'b1);
        queue_walks(60, 0);
        settle();
        repeat (40) @(posedge clk);

        $display("Run covered %0d commands: create %0d, map %0d, unmap %0d, translate %0d",
                 cmd_seen[ACT_CREATE] + cmd_seen[ACT_MAP] + cmd_seen[ACT_UNMAP] +
                 cmd_seen[ACT_TRANSLATE], cmd_seen[ACT_CREATE], cmd_seen[ACT_MAP],
                 cmd_seen[ACT_UNMAP], cmd_seen[ACT_TRANSLATE]);
        $display("Checked %0d: ok %0d full %0d user %0d unmapped %0d no root %0d; tables %0d",
                 checked, status_seen[ST_OK], status_seen[ST_NO_TABLES],
                 status_seen[ST_NOT_USER], status_seen[ST_NOT_MAPPED],
                 status_seen[ST_NO_ROOT], tables_used);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> page_table_map_walk_engine.f
rtl/core/ptwe_pkg.sv
rtl/core/ptwe_cmd_if.sv
rtl/core/ptwe_rsp_if.sv
rtl/core/ptwe_ram.sv
rtl/core/page_table_map_walk_engine.sv
tb/page_table_map_walk_engine_tb.sv
